@@ rtl/blt_pkg.sv @@
// Shared types, constants and coefficient tables for the biquaternion Lorentz transform.
`timescale 1ns / 1ps

package blt_pkg;

    // Word formats: Q parts in Q8.24, four-vectors in Q16.16 at a 32-bit word.
    localparam int WORD_W   = 32;
    localparam int Q_FRAC   = WORD_W - 8;
    localparam int DROP     = 2 * Q_FRAC;

    // Register bank and index widths.
    localparam int NUM_REGS  = 8;
    localparam int QSEL_W    = $clog2(NUM_REGS);
    localparam int CFG_IDX_W = QSEL_W + 1;

    // Counts of intermediate values and product terms.
    localparam int NUM_P    = 8;
    localparam int NUM_V    = 4;
    localparam int NUM_OUT  = 4;
    localparam int NUM_TERM = 8;
    localparam int PSEL_W   = $clog2(NUM_P);

    // Datapath widths. A negated Q part needs one extra bit.
    localparam int QN_W    = WORD_W + 1;
    localparam int PROD1_W = 2 * WORD_W;
    localparam int PAIR1_W = PROD1_W + 1;
    localparam int P_W     = PROD1_W + 2;
    localparam int SPLIT_W = WORD_W;
    localparam int HI_W    = P_W - SPLIT_W;
    localparam int PH_W    = HI_W + QN_W;
    localparam int PL_W    = SPLIT_W + 1 + QN_W;
    localparam int TW      = PH_W + SPLIT_W + 5;
    localparam int SH_W    = TW - DROP;

    // Q register indexes, in configuration order.
    localparam logic [QSEL_W-1:0] Q0_RE = QSEL_W'(0);
    localparam logic [QSEL_W-1:0] Q0_IM = QSEL_W'(1);
    localparam logic [QSEL_W-1:0] Q1_RE = QSEL_W'(2);
    localparam logic [QSEL_W-1:0] Q1_IM = QSEL_W'(3);
    localparam logic [QSEL_W-1:0] Q2_RE = QSEL_W'(4);
    localparam logic [QSEL_W-1:0] Q2_IM = QSEL_W'(5);
    localparam logic [QSEL_W-1:0] Q3_RE = QSEL_W'(6);
    localparam logic [QSEL_W-1:0] Q3_IM = QSEL_W'(7);

    // Indexes of the real and imaginary parts of P = Q V.
    localparam logic [PSEL_W-1:0] P0_RE = PSEL_W'(0);
    localparam logic [PSEL_W-1:0] P0_IM = PSEL_W'(1);
    localparam logic [PSEL_W-1:0] P1_RE = PSEL_W'(2);
    localparam logic [PSEL_W-1:0] P1_IM = PSEL_W'(3);
    localparam logic [PSEL_W-1:0] P2_RE = PSEL_W'(4);
    localparam logic [PSEL_W-1:0] P2_IM = PSEL_W'(5);
    localparam logic [PSEL_W-1:0] P3_RE = PSEL_W'(6);
    localparam logic [PSEL_W-1:0] P3_IM = PSEL_W'(7);

    // Output component indexes.
    localparam int OUT_T = 0;
    localparam int OUT_X = 1;
    localparam int OUT_Y = 2;
    localparam int OUT_Z = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [NUM_REGS-1:0]     qbank_t;
    typedef logic signed [P_W-1:0]    pval_t;
    typedef pval_t [NUM_P-1:0]        pbank_t;

    typedef struct packed {
        word_t time_in;
        word_t x_in;
        word_t y_in;
        word_t z_in;
    } vec_t;

    typedef struct packed {
        word_t time_out;
        word_t x_out;
        word_t y_out;
        word_t z_out;
        logic  overflow;
    } res_t;

    localparam word_t Q_ONE    = WORD_W'(1) << Q_FRAC;
    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Reset contents of the Q bank: the identity transform, q0_re = 1.0 in the lowest slot.
    localparam qbank_t QBANK_RESET = qbank_t'({{((NUM_REGS-1)*WORD_W){1'b0}}, Q_ONE});

    // Half of the last kept bit, for round half up.
    localparam logic signed [TW-1:0] ROUND_BIAS = TW'(1) <<< (DROP - 1);

    // P = Q V. Term j of every row multiplies the j-th vector component (t, x, y, z).
    localparam logic [QSEL_W-1:0] QV_QSEL [NUM_P][NUM_V] = '{
        '{Q0_RE, Q1_IM, Q2_IM, Q3_IM},
        '{Q0_IM, Q1_RE, Q2_RE, Q3_RE},
        '{Q1_RE, Q0_IM, Q3_IM, Q2_IM},
        '{Q1_IM, Q0_RE, Q3_RE, Q2_RE},
        '{Q2_RE, Q3_IM, Q0_IM, Q1_IM},
        '{Q2_IM, Q3_RE, Q0_RE, Q1_RE},
        '{Q3_RE, Q2_IM, Q1_IM, Q0_IM},
        '{Q3_IM, Q2_RE, Q1_RE, Q0_RE}
    };

    localparam logic QV_NEG [NUM_P][NUM_V] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b1, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0}
    };

    // W = P Q+, only Re W0 and Im W1..W3. The conjugate signs are folded into the table.
    localparam logic [PSEL_W-1:0] PQ_PSEL [NUM_OUT][NUM_TERM] = '{
        '{P0_RE, P0_IM, P1_RE, P1_IM, P2_RE, P2_IM, P3_RE, P3_IM},
        '{P0_RE, P0_IM, P1_IM, P1_RE, P2_RE, P2_IM, P3_RE, P3_IM},
        '{P0_RE, P0_IM, P2_IM, P2_RE, P3_RE, P3_IM, P1_RE, P1_IM},
        '{P0_RE, P0_IM, P3_IM, P3_RE, P1_RE, P1_IM, P2_RE, P2_IM}
    };

    localparam logic [QSEL_W-1:0] PQ_QSEL [NUM_OUT][NUM_TERM] = '{
        '{Q0_RE, Q0_IM, Q1_RE, Q1_IM, Q2_RE, Q2_IM, Q3_RE, Q3_IM},
        '{Q1_IM, Q1_RE, Q0_RE, Q0_IM, Q3_IM, Q3_RE, Q2_IM, Q2_RE},
        '{Q2_IM, Q2_RE, Q0_RE, Q0_IM, Q1_IM, Q1_RE, Q3_IM, Q3_RE},
        '{Q3_IM, Q3_RE, Q0_RE, Q0_IM, Q2_IM, Q2_RE, Q1_IM, Q1_RE}
    };

    localparam logic PQ_NEG [NUM_OUT][NUM_TERM] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}
    };

endpackage

@@ rtl/blt_cfg.sv @@
// Configuration register bank holding the biquaternion Q.
`timescale 1ns / 1ps

module blt_cfg
    import blt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output qbank_t               qbank
);

    qbank_t qbank_reg;
    qbank_t qbank_next;

    // Writes are always taken; an index past the bank is dropped.
    assign cfg_ready = 1'b1;

    // Register write decode.
    always_comb
    begin
        qbank_next = qbank_reg;
        if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS)))
            qbank_next[cfg_index[QSEL_W-1:0]] = cfg_data;
    end

    // Reset loads the identity transform.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qbank_reg <= QBANK_RESET;
        end
        else
        begin
            qbank_reg <= qbank_next;
        end
    end

    assign qbank = qbank_reg;

endmodule

@@ rtl/blt_qv.sv @@
// Front pipeline: forms P = Q V in three register stages.
`timescale 1ns / 1ps

module blt_qv
    import blt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  vec_t   in_data,
    input  qbank_t qbank,
    output logic   p_valid,
    input  logic   p_ready,
    output pbank_t p_data
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] stage_en;

    word_t                     vsel      [NUM_V];
    logic signed [QN_W-1:0]    qn        [NUM_P][NUM_V];
    logic signed [PROD1_W-1:0] prod_reg  [NUM_P][NUM_V];
    logic signed [PROD1_W-1:0] prod_next [NUM_P][NUM_V];
    logic signed [PAIR1_W-1:0] pair_reg  [NUM_P][NUM_V/2];
    logic signed [PAIR1_W-1:0] pair_next [NUM_P][NUM_V/2];
    pbank_t                    p_reg;
    pbank_t                    p_next;

    // A stage loads when it is empty or its word moves on downstream.
    always_comb
    begin
        stage_en[NSTG-1] = !valid_reg[NSTG-1] || p_ready;
        for (int k = NSTG - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    // Valid bits travel with their words.
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
            valid_next[0] = in_valid;
        for (int k = 1; k < NSTG; k++)
            if (stage_en[k])
                valid_next[k] = valid_reg[k-1];
    end

    // First stage: thirty-two-way set of Q part by vector component products, signs applied up front.
    always_comb
    begin
        vsel[0] = in_data.time_in;
        vsel[1] = in_data.x_in;
        vsel[2] = in_data.y_in;
        vsel[3] = in_data.z_in;
        for (int p = 0; p < NUM_P; p++)
        begin
            for (int j = 0; j < NUM_V; j++)
            begin
                if (QV_NEG[p][j])
                    qn[p][j] = -QN_W'($signed(qbank[QV_QSEL[p][j]]));
                else
                    qn[p][j] = QN_W'($signed(qbank[QV_QSEL[p][j]]));
                prod_next[p][j] = PROD1_W'(qn[p][j]) * PROD1_W'(vsel[j]);
            end
        end
    end

    // Second stage: pairwise sums.
    always_comb
    begin
        for (int p = 0; p < NUM_P; p++)
            for (int h = 0; h < NUM_V / 2; h++)
                pair_next[p][h] = PAIR1_W'(prod_reg[p][2*h]) + PAIR1_W'(prod_reg[p][2*h+1]);
    end

    // Third stage: the parts of P.
    always_comb
    begin
        for (int p = 0; p < NUM_P; p++)
            p_next[p] = P_W'(pair_reg[p][0]) + P_W'(pair_reg[p][1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            prod_reg <= prod_next;
        if (stage_en[1])
            pair_reg <= pair_next;
        if (stage_en[2])
            p_reg <= p_next;
    end

    assign in_ready = stage_en[0];
    assign p_valid  = valid_reg[NSTG-1];
    assign p_data   = p_reg;

endmodule

@@ rtl/blt_pq.sv @@
// Back pipeline: forms W = P Q+ with split products, then rounds and saturates.
`timescale 1ns / 1ps

module blt_pq
    import blt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   p_valid,
    output logic   p_ready,
    input  pbank_t p_data,
    input  qbank_t qbank,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_data
);

    localparam int NSTG  = 6;
    localparam int HS1_W = PH_W + 1;
    localparam int HS2_W = PH_W + 2;
    localparam int HS3_W = PH_W + 3;
    localparam int LS1_W = PL_W + 1;
    localparam int LS2_W = PL_W + 2;
    localparam int LS3_W = PL_W + 3;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] stage_en;

    pval_t                   pv        [NUM_OUT][NUM_TERM];
    logic signed [QN_W-1:0]  qn        [NUM_OUT][NUM_TERM];
    logic signed [PH_W-1:0]  ph_reg    [NUM_OUT][NUM_TERM];
    logic signed [PH_W-1:0]  ph_next   [NUM_OUT][NUM_TERM];
    logic signed [PL_W-1:0]  pl_reg    [NUM_OUT][NUM_TERM];
    logic signed [PL_W-1:0]  pl_next   [NUM_OUT][NUM_TERM];
    logic signed [HS1_W-1:0] hs1_reg   [NUM_OUT][NUM_TERM/2];
    logic signed [HS1_W-1:0] hs1_next  [NUM_OUT][NUM_TERM/2];
    logic signed [LS1_W-1:0] ls1_reg   [NUM_OUT][NUM_TERM/2];
    logic signed [LS1_W-1:0] ls1_next  [NUM_OUT][NUM_TERM/2];
    logic signed [HS2_W-1:0] hs2_reg   [NUM_OUT][NUM_TERM/4];
    logic signed [HS2_W-1:0] hs2_next  [NUM_OUT][NUM_TERM/4];
    logic signed [LS2_W-1:0] ls2_reg   [NUM_OUT][NUM_TERM/4];
    logic signed [LS2_W-1:0] ls2_next  [NUM_OUT][NUM_TERM/4];
    logic signed [HS3_W-1:0] hs3_reg   [NUM_OUT];
    logic signed [HS3_W-1:0] hs3_next  [NUM_OUT];
    logic signed [LS3_W-1:0] ls3_reg   [NUM_OUT];
    logic signed [LS3_W-1:0] ls3_next  [NUM_OUT];
    logic signed [TW-1:0]    total_reg [NUM_OUT];
    logic signed [TW-1:0]    total_next[NUM_OUT];

    logic [SH_W-1:0]        sh    [NUM_OUT];
    logic [SH_W-WORD_W:0]   upper [NUM_OUT];
    logic [NUM_OUT-1:0]     ovf;
    word_t                  sat   [NUM_OUT];
    res_t                   out_reg;
    res_t                   out_next;

    // A stage loads when it is empty or its word moves on downstream.
    always_comb
    begin
        stage_en[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    // Valid bits travel with their words.
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
            valid_next[0] = p_valid;
        for (int k = 1; k < NSTG; k++)
            if (stage_en[k])
                valid_next[k] = valid_reg[k-1];
    end

    // Products of P and Q parts; P is split into a signed high half and an unsigned low word.
    always_comb
    begin
        for (int o = 0; o < NUM_OUT; o++)
        begin
            for (int j = 0; j < NUM_TERM; j++)
            begin
                pv[o][j] = p_data[PQ_PSEL[o][j]];
                if (PQ_NEG[o][j])
                    qn[o][j] = -QN_W'($signed(qbank[PQ_QSEL[o][j]]));
                else
                    qn[o][j] = QN_W'($signed(qbank[PQ_QSEL[o][j]]));
                ph_next[o][j] = PH_W'($signed(pv[o][j][P_W-1:SPLIT_W])) * PH_W'(qn[o][j]);
                pl_next[o][j] = PL_W'($signed({1'b0, pv[o][j][SPLIT_W-1:0]}))
                              * PL_W'(qn[o][j]);
            end
        end
    end

    // Adder tree over the eight terms, high and low halves kept apart.
    always_comb
    begin
        for (int o = 0; o < NUM_OUT; o++)
        begin
            for (int h = 0; h < NUM_TERM / 2; h++)
            begin
                hs1_next[o][h] = HS1_W'(ph_reg[o][2*h]) + HS1_W'(ph_reg[o][2*h+1]);
                ls1_next[o][h] = LS1_W'(pl_reg[o][2*h]) + LS1_W'(pl_reg[o][2*h+1]);
            end
            for (int h = 0; h < NUM_TERM / 4; h++)
            begin
                hs2_next[o][h] = HS2_W'(hs1_reg[o][2*h]) + HS2_W'(hs1_reg[o][2*h+1]);
                ls2_next[o][h] = LS2_W'(ls1_reg[o][2*h]) + LS2_W'(ls1_reg[o][2*h+1]);
            end
            hs3_next[o] = HS3_W'(hs2_reg[o][0]) + HS3_W'(hs2_reg[o][1]);
            ls3_next[o] = LS3_W'(ls2_reg[o][0]) + LS3_W'(ls2_reg[o][1]);
        end
    end

    // Recombine the halves and add the rounding bias.
    always_comb
    begin
        for (int o = 0; o < NUM_OUT; o++)
            total_next[o] = (TW'(hs3_reg[o]) <<< SPLIT_W) + TW'(ls3_reg[o]) + ROUND_BIAS;
    end

    // Drop the fraction bits and saturate to the word range.
    always_comb
    begin
        for (int o = 0; o < NUM_OUT; o++)
        begin
            sh[o]    = total_reg[o][TW-1:DROP];
            upper[o] = sh[o][SH_W-1:WORD_W-1];
            ovf[o]   = !((&upper[o]) || !(|upper[o]));
            if (ovf[o])
                sat[o] = sh[o][SH_W-1] ? WORD_MIN : WORD_MAX;
            else
                sat[o] = sh[o][WORD_W-1:0];
        end
        out_next.time_out = sat[OUT_T];
        out_next.x_out    = sat[OUT_X];
        out_next.y_out    = sat[OUT_Y];
        out_next.z_out    = sat[OUT_Z];
        out_next.overflow = |ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (stage_en[1])
        begin
            hs1_reg <= hs1_next;
            ls1_reg <= ls1_next;
        end
        if (stage_en[2])
        begin
            hs2_reg <= hs2_next;
            ls2_reg <= ls2_next;
        end
        if (stage_en[3])
        begin
            hs3_reg <= hs3_next;
            ls3_reg <= ls3_next;
        end
        if (stage_en[4])
            total_reg <= total_next;
        if (stage_en[5])
            out_reg <= out_next;
    end

    assign p_ready   = stage_en[0];
    assign out_valid = valid_reg[NSTG-1];
    assign out_data  = out_reg;

endmodule

@@ rtl/biquaternion_lorentz_transform.sv @@
// An accepted word passes the blt_qv stages (P = Q V), then the blt_pq stages (W = P Q+).
// Throughput: one four-vector per cycle while out_ready stays high, over nine pipeline stages.
// Each stage holds its word under stall and takes a new one as soon as it empties.
// Reset clears all valid bits and loads Q with the identity (q0_re = 1.0, all others 0).
// Top level of the biquaternion Lorentz transform.
`timescale 1ns / 1ps

module biquaternion_lorentz_transform
    import blt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vec_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_t                 out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    qbank_t qbank;
    logic   p_valid;
    logic   p_ready;
    pbank_t p_data;

    // Q register bank.
    blt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qbank     (qbank)
    );

    // P = Q V.
    blt_qv u_qv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .qbank    (qbank),
        .p_valid  (p_valid),
        .p_ready  (p_ready),
        .p_data   (p_data)
    );

    // W = P Q+, rounded and saturated.
    blt_pq u_pq (
        .clk       (clk),
        .rst_n     (rst_n),
        .p_valid   (p_valid),
        .p_ready   (p_ready),
        .p_data    (p_data),
        .qbank     (qbank),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ tb/sv/biquaternion_lorentz_transform_tb.sv @@
// Self-checking testbench for the biquaternion Lorentz transform block.
`timescale 1ns / 1ps

module biquaternion_lorentz_transform_tb;
    import blt_pkg::*;

    // Run shape.
    localparam int PIPE_DEPTH      = 9;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_PHASE     = 5;

    // One unit in the Q16.16 vector format.
    localparam word_t V_ONE = word_t'(1) << (WORD_W / 2);

    // Exact products need about 100 bits; this leaves plenty of headroom.
    typedef logic signed [159:0] wide_t;

    // Kinds of transform settings used by the random phases.
    typedef enum {
        BANK_ROTATE,
        BANK_BOOST,
        BANK_RAW,
        BANK_SMALL,
        BANK_EXTREME,
        BANK_ALL_MAX,
        BANK_ALL_MIN,
        BANK_ZERO
    } bank_kind_e;

    localparam bank_kind_e PHASE_PLAN [NUM_PHASES] = '{
        BANK_ROTATE, BANK_BOOST, BANK_RAW, BANK_SMALL, BANK_ALL_MAX, BANK_ROTATE,
        BANK_EXTREME, BANK_ALL_MIN, BANK_BOOST, BANK_ZERO, BANK_SMALL, BANK_ROTATE
    };

    // Holds a copy of the Q registers, predicts each transformed vector and
    // checks the block's results in order.
    class lorentz_scoreboard;
        word_t q_regs [NUM_REGS];
        res_t  expected_results [$];
        int    errors;

        function new();
            foreach (q_regs[k]) q_regs[k] = '0;
            q_regs[Q0_RE] = Q_ONE;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
            // Indexes past the bank are dropped by the block.
            if (idx < NUM_REGS) q_regs[idx] = val;
        endfunction

        function wide_t widen(word_t w);
            return w;
        endfunction

        // Complex quaternion product r = a b.
        function void quat_mul(input wide_t ar [4], input wide_t ai [4],
                               input wide_t br [4], input wide_t bi [4],
                               output wide_t rr [4], output wide_t ri [4]);
            wide_t cr [4][4];
            wide_t ci [4][4];
            int    i;
            int    j;
            for (i = 0; i < 4; i++)
            begin
                for (j = 0; j < 4; j++)
                begin
                    cr[i][j] = ar[i] * br[j] - ai[i] * bi[j];
                    ci[i][j] = ar[i] * bi[j] + ai[i] * br[j];
                end
            end
            rr[0] = cr[0][0] - cr[1][1] - cr[2][2] - cr[3][3];
            ri[0] = ci[0][0] - ci[1][1] - ci[2][2] - ci[3][3];
            rr[1] = cr[0][1] + cr[1][0] + cr[2][3] - cr[3][2];
            ri[1] = ci[0][1] + ci[1][0] + ci[2][3] - ci[3][2];
            rr[2] = cr[0][2] + cr[2][0] + cr[3][1] - cr[1][3];
            ri[2] = ci[0][2] + ci[2][0] + ci[3][1] - ci[1][3];
            rr[3] = cr[0][3] + cr[3][0] + cr[1][2] - cr[2][1];
            ri[3] = ci[0][3] + ci[3][0] + ci[1][2] - ci[2][1];
        endfunction

        // Round half up, drop the fraction bits of both Q factors, then saturate.
        function word_t round_sat(wide_t acc, inout bit ov);
            wide_t scaled;
            wide_t top;
            wide_t bottom;
            scaled = (acc + (wide_t'(1) <<< (DROP - 1))) >>> DROP;
            top    = widen(WORD_MAX);
            bottom = widen(WORD_MIN);
            if (scaled > top)
            begin
                ov = 1'b1;
                return WORD_MAX;
            end
            if (scaled < bottom)
            begin
                ov = 1'b1;
                return WORD_MIN;
            end
            return word_t'(scaled);
        endfunction

        // W = Q V Q+, with V = [t, i x, i y, i z].
        function res_t lorentz_apply(vec_t v);
            wide_t qr [4];
            wide_t qi [4];
            wide_t hr [4];
            wide_t hi [4];
            wide_t vr [4];
            wide_t vi [4];
            wide_t pr [4];
            wide_t pi [4];
            wide_t wr [4];
            wide_t wi [4];
            res_t  r;
            bit    ov;
            int    k;
            qr[0] = widen(q_regs[Q0_RE]);
            qi[0] = widen(q_regs[Q0_IM]);
            qr[1] = widen(q_regs[Q1_RE]);
            qi[1] = widen(q_regs[Q1_IM]);
            qr[2] = widen(q_regs[Q2_RE]);
            qi[2] = widen(q_regs[Q2_IM]);
            qr[3] = widen(q_regs[Q3_RE]);
            qi[3] = widen(q_regs[Q3_IM]);

            // Hermitian conjugate: conjugate the scalar, negate-conjugate the vector part.
            hr[0] = qr[0];
            hi[0] = -qi[0];
            for (k = 1; k < 4; k++)
            begin
                hr[k] = -qr[k];
                hi[k] = qi[k];
            end

            vr[0] = widen(v.time_in);
            vi[0] = '0;
            vr[1] = '0;
            vi[1] = widen(v.x_in);
            vr[2] = '0;
            vi[2] = widen(v.y_in);
            vr[3] = '0;
            vi[3] = widen(v.z_in);

            quat_mul(qr, qi, vr, vi, pr, pi);
            quat_mul(pr, pi, hr, hi, wr, wi);

            ov = 1'b0;
            r.time_out = round_sat(wr[0], ov);
            r.x_out    = round_sat(wi[1], ov);
            r.y_out    = round_sat(wi[2], ov);
            r.z_out    = round_sat(wi[3], ov);
            r.overflow = ov;
            return r;
        endfunction

        function void note_input(vec_t v);
            expected_results.push_back(lorentz_apply(v));
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        function void compare_field(string name, word_t want, word_t got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("time_out", want.time_out, got.time_out);
            compare_field("x_out", want.x_out, got.x_out);
            compare_field("y_out", want.y_out, got.y_out);
            compare_field("z_out", want.z_out, got.z_out);
            compare_field("overflow", word_t'(want.overflow), word_t'(got.overflow));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    vec_t                 in_data;
    logic                 out_valid;
    logic                 out_ready;
    res_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    lorentz_scoreboard board = new();

    // Idle levels in percent, and a long receiver hold-off request in cycles.
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_len     = 0;
    int cycle_count  = 0;

    biquaternion_lorentz_transform uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic vec_t mk_vec(word_t t, word_t x, word_t y, word_t z);
        vec_t v;
        v.time_in = t;
        v.x_in    = x;
        v.y_in    = y;
        v.z_in    = z;
        return v;
    endfunction

    function automatic word_t pick_extreme();
        case ($urandom_range(0, 4))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return word_t'(1);
            default: return word_t'(-1);
        endcase
    endfunction

    // Mostly raw words, a good share of small physical values, a few extremes.
    function automatic word_t rand_field();
        case ($urandom_range(0, 9))
            0:          return pick_extreme();
            1, 2, 3, 4: return word_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default:    return word_t'($urandom);
        endcase
    endfunction

    function automatic vec_t rand_vec();
        return mk_vec(rand_field(), rand_field(), rand_field(), rand_field());
    endfunction

    function automatic real rand_unit();
        return real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
    endfunction

    function automatic word_t to_q(real r);
        return word_t'($rtoi(r * real'(Q_ONE)));
    endfunction

    function automatic qbank_t make_bank(bank_kind_e kind);
        qbank_t b;
        real    ax;
        real    ay;
        real    az;
        real    norm;
        real    half;
        int     k;
        b  = '0;
        ax = rand_unit();
        ay = rand_unit();
        az = rand_unit();
        norm = $sqrt(ax * ax + ay * ay + az * az);
        if (norm < 0.001)
        begin
            ax   = 1.0;
            norm = 1.0;
        end
        case (kind)
            // Spatial rotation about a random axis.
            BANK_ROTATE:
            begin
                half = real'($urandom_range(0, 6283)) / 2000.0;
                b[Q0_RE] = to_q($cos(half));
                b[Q1_RE] = to_q($sin(half) * ax / norm);
                b[Q2_RE] = to_q($sin(half) * ay / norm);
                b[Q3_RE] = to_q($sin(half) * az / norm);
            end
            // Boost along a random direction, rapidity up to 3.
            BANK_BOOST:
            begin
                half = real'($urandom_range(0, 1500)) / 1000.0;
                b[Q0_RE] = to_q($cosh(half));
                b[Q1_IM] = to_q(-$sinh(half) * ax / norm);
                b[Q2_IM] = to_q(-$sinh(half) * ay / norm);
                b[Q3_IM] = to_q(-$sinh(half) * az / norm);
            end
            BANK_RAW:
                for (k = 0; k < NUM_REGS; k++) b[k] = word_t'($urandom);
            BANK_SMALL:
                for (k = 0; k < NUM_REGS; k++)
                    b[k] = word_t'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
            BANK_EXTREME:
                for (k = 0; k < NUM_REGS; k++) b[k] = pick_extreme();
            BANK_ALL_MAX:
                for (k = 0; k < NUM_REGS; k++) b[k] = WORD_MAX;
            BANK_ALL_MIN:
                for (k = 0; k < NUM_REGS; k++) b[k] = WORD_MIN;
            default:
                b = '0;
        endcase
        return b;
    endfunction

    // Offer one four-vector word and hold it until the block takes it.
    task automatic push_vec(input vec_t v);
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(v);
    endtask

    task automatic src_pause(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_count() != 0);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
    endtask

    // Write all Q registers, sometimes followed by a write past the bank.
    task automatic load_bank(input qbank_t bank);
        int i;
        for (i = 0; i < NUM_REGS; i++) cfg_write(CFG_IDX_W'(i), bank[i]);
        if ($urandom_range(0, 1) == 1)
            cfg_write(CFG_IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1)),
                      word_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Receiver: checks each accepted result word and stalls in bursts.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) board.check_result(out_data);
            if (hold_len != 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Sender and configuration sequence.
    initial
    begin
        qbank_t bank;
        int     p;
        int     n;
        bit     is_last;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity transform straight out of reset: values must pass unchanged.
        src_idle_pct = 25;
        snk_idle_pct = 25;
        push_vec(mk_vec('0, '0, '0, '0));
        push_vec(mk_vec(word_t'(1), word_t'(-1), word_t'(1), word_t'(-1)));
        push_vec(mk_vec(word_t'(-1), word_t'(1), word_t'(-1), word_t'(1)));
        push_vec(mk_vec(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        push_vec(mk_vec(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        push_vec(mk_vec(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
        push_vec(mk_vec(V_ONE, '0, '0, '0));
        push_vec(mk_vec('0, V_ONE, '0, '0));
        push_vec(mk_vec('0, '0, V_ONE, '0));
        push_vec(mk_vec('0, '0, '0, V_ONE));
        wait_drained();

        // A half Q0_RE scales vectors by a quarter; inputs of 2 and -2 land on exact halves, which round up.
        bank = '0;
        bank[Q0_RE] = Q_ONE >>> 1;
        load_bank(bank);
        push_vec(mk_vec(word_t'(2), word_t'(-2), word_t'(2), word_t'(-2)));
        push_vec(mk_vec(word_t'(-2), word_t'(2), word_t'(-2), word_t'(2)));
        push_vec(mk_vec(word_t'(1), word_t'(3), word_t'(-1), word_t'(-3)));
        wait_drained();

        // A large, non-unit Q saturates both ways.
        bank = '0;
        bank[Q0_RE] = WORD_MAX;
        bank[Q2_IM] = Q_ONE;
        load_bank(bank);
        push_vec(mk_vec(V_ONE, V_ONE, V_ONE, V_ONE));
        push_vec(mk_vec(-V_ONE, -V_ONE, -V_ONE, -V_ONE));
        push_vec(mk_vec(WORD_MAX, WORD_MIN, '0, word_t'(1)));
        push_vec(mk_vec(word_t'(1), '0, '0, '0));
        wait_drained();

        // Random phases, one transform setting each.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            is_last = (p == NUM_PHASES - 1);
            case (p % 3)
                0:       src_idle_pct = 0;
                1:       src_idle_pct = 10;
                default: src_idle_pct = 40;
            endcase
            case ((p + 1) % 3)
                0:       snk_idle_pct = 0;
                1:       snk_idle_pct = 10;
                default: snk_idle_pct = 40;
            endcase
            if (is_last)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            load_bank(make_bank(PHASE_PLAN[p]));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Long receiver hold-off while the sender keeps offering words.
                if (p == HOLD_PHASE && n == 40) hold_len = HOLD_CYCLES;
                if (p == DRAIN_PHASE && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
                    src_pause($urandom_range(1, 19));
                push_vec(rand_vec());
            end
            wait_drained();
        end

        if (board.errors == 0 && board.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/blt_pkg.sv
rtl/blt_cfg.sv
rtl/blt_qv.sv
rtl/blt_pq.sv
rtl/biquaternion_lorentz_transform.sv
tb/sv/biquaternion_lorentz_transform_tb.sv
